// ===== rtl/acsc_pkg.sv =====
// ----------------------------------------------------------------------------
// acsc_pkg: shared types and helpers for the alarm clock set controller
// Holds the event codes, the mode encoding, the controller state record and
// the wrap-around field arithmetic for hours, minutes and seconds.
// ----------------------------------------------------------------------------
package acsc_pkg;

  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned SecW  = 6;

  localparam logic [HourW-1:0] HoursPerDay = HourW'(24);
  localparam logic [MinW-1:0]  MinsPerHour = MinW'(60);
  localparam logic [HourW-1:0] LastHour    = HourW'(23);
  localparam logic [MinW-1:0]  LastMinSec  = MinW'(59);

  typedef enum logic [2:0] {
    CMD_UPDATE = 3'd0,
    CMD_SHORT  = 3'd1,
    CMD_LONG   = 3'd2,
    CMD_UP     = 3'd3,
    CMD_DOWN   = 3'd4,
    CMD_RIGHT  = 3'd5,
    CMD_LEFT   = 3'd6,
    CMD_LOAD   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ALM_HR  = 3'd1,
    MODE_ALM_MIN = 3'd2,
    MODE_ALM_SEC = 3'd3,
    MODE_RINGING = 3'd4,
    MODE_CLK_HR  = 3'd5,
    MODE_CLK_MIN = 3'd6,
    MODE_CLK_SEC = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [HourW-1:0]  edit_h;
    logic [MinW-1:0]   edit_m;
    logic [SecW-1:0]   edit_s;
    logic [HourW-1:0]  alarm_h;
    logic [MinW-1:0]   alarm_m;
    logic [HourW-1:0]  seen_h;
    logic [MinW-1:0]   seen_m;
    logic [SecW-1:0]   seen_s;
  } acsc_state_t;

  typedef struct packed {
    logic save_alarm;
    logic set_clock;
  } acsc_strobe_t;

  // sum stays below twice the modulus, so one subtract reduces it
  function automatic logic [HourW-1:0] hour_inc(input logic [HourW-1:0] v);
    logic [HourW:0] sum;
    sum = {1'b0, v} + (HourW+1)'(1);
    if (sum >= {1'b0, HoursPerDay}) begin
      sum = sum - {1'b0, HoursPerDay};
    end
    return sum[HourW-1:0];
  endfunction

  function automatic logic [MinW-1:0] min_inc(input logic [MinW-1:0] v);
    logic [MinW:0] sum;
    sum = {1'b0, v} + (MinW+1)'(1);
    if (sum >= {1'b0, MinsPerHour}) begin
      sum = sum - {1'b0, MinsPerHour};
    end
    return sum[MinW-1:0];
  endfunction

  function automatic logic [HourW-1:0] hour_dec(input logic [HourW-1:0] v);
    return (v == '0) ? LastHour : v - HourW'(1);
  endfunction

  function automatic logic [MinW-1:0] min_dec(input logic [MinW-1:0] v);
    return (v == '0) ? LastMinSec : v - MinW'(1);
  endfunction

endpackage

// ===== rtl/acsc_next.sv =====
// ----------------------------------------------------------------------------
// acsc_next: next-state logic of the alarm clock set controller
// Applies one event to the current state, produces the strobes and then
// checks the stored clock time against the alarm to enter ringing.
// ----------------------------------------------------------------------------
module acsc_next
  import acsc_pkg::*;
(
  input  acsc_state_t       cur,
  input  cmd_t              cmd,
  input  logic [HourW-1:0]  hours,
  input  logic [MinW-1:0]   minutes,
  input  logic [SecW-1:0]   seconds,
  output acsc_state_t       nxt,
  output acsc_strobe_t      strobe
);

  logic press;

  assign press = (cmd == CMD_SHORT) || (cmd == CMD_LONG);

  always_comb begin
    nxt    = cur;
    strobe = '0;

    if (cmd == CMD_LOAD) begin
      nxt.alarm_h = hours;
      nxt.alarm_m = minutes;
    end else if (cur.mode == MODE_NORMAL) begin
      if (press) begin
        // edit time starts from the clock time seen before this event
        nxt.edit_h = cur.seen_h;
        nxt.edit_m = cur.seen_m;
        nxt.mode   = (cmd == CMD_LONG) ? MODE_ALM_HR : MODE_CLK_HR;
        nxt.seen_h = hours;
        nxt.seen_m = minutes;
        nxt.seen_s = seconds;
      end else if (cmd == CMD_UPDATE) begin
        nxt.seen_h = hours;
        nxt.seen_m = minutes;
        nxt.seen_s = seconds;
      end
    end else if (cur.mode == MODE_RINGING) begin
      if (press) begin
        nxt.seen_h = hours;
        nxt.seen_m = minutes;
        nxt.seen_s = seconds;
        nxt.mode   = MODE_NORMAL;
      end
    end else if (press) begin
      if (cur.mode <= MODE_ALM_SEC) begin
        nxt.alarm_h       = cur.edit_h;
        nxt.alarm_m       = cur.edit_m;
        strobe.save_alarm = 1'b1;
      end else begin
        strobe.set_clock = 1'b1;
      end
      nxt.mode = MODE_NORMAL;
    end else if (cmd == CMD_UP || cmd == CMD_DOWN) begin
      unique case (cur.mode)
        MODE_ALM_HR, MODE_CLK_HR: begin
          nxt.edit_h = (cmd == CMD_UP) ? hour_inc(cur.edit_h) : hour_dec(cur.edit_h);
        end
        MODE_ALM_MIN, MODE_CLK_MIN: begin
          nxt.edit_m = (cmd == CMD_UP) ? min_inc(cur.edit_m) : min_dec(cur.edit_m);
        end
        MODE_ALM_SEC, MODE_CLK_SEC: begin
          nxt.edit_s = (cmd == CMD_UP) ? min_inc(cur.edit_s) : min_dec(cur.edit_s);
        end
        default: begin
          nxt.edit_h = cur.edit_h;
        end
      endcase
    end else if (cmd == CMD_RIGHT) begin
      if (cur.mode == MODE_ALM_HR || cur.mode == MODE_ALM_MIN ||
          cur.mode == MODE_CLK_HR || cur.mode == MODE_CLK_MIN) begin
        nxt.mode = mode_t'(cur.mode + 3'd1);
      end
    end else if (cmd == CMD_LEFT) begin
      // left stays inside its setting group
      if (cur.mode == MODE_ALM_MIN || cur.mode == MODE_ALM_SEC ||
          cur.mode == MODE_CLK_MIN || cur.mode == MODE_CLK_SEC) begin
        nxt.mode = mode_t'(cur.mode - 3'd1);
      end
    end

    // alarm seconds are always zero
    if (nxt.seen_h == nxt.alarm_h && nxt.seen_m == nxt.alarm_m && nxt.seen_s == '0) begin
      nxt.mode = MODE_RINGING;
    end
  end

endmodule

// ===== rtl/alarm_clock_set_controller.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_set_controller: mode controller of an alarm clock
// Takes one event per transaction and returns the mode, edit time, alarm
// setting and commit strobes after that event.
// ----------------------------------------------------------------------------
// One event is taken every clock cycle while in_tready is high. Each event
// passes an input register, one pass of next-state logic and a result
// register. The input register takes one more event while a finished result
// waits at the output; back-pressure reaches in_tready only when both
// registers are full. No clearing pass follows reset.
module alarm_clock_set_controller
  import acsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // command
  input  logic [23:0] in_tdata,   // now_hours, now_minutes, now_seconds, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // mode_now, edit_hours, edit_minutes, edit_seconds,
                                  // alarm_hours_out, alarm_minutes_out, save_alarm,
                                  // set_clock, ringing, zero pad
);

  logic              in_valid_r;
  cmd_t              in_cmd_r;
  logic [HourW-1:0]  in_hours_r;
  logic [MinW-1:0]   in_minutes_r;
  logic [SecW-1:0]   in_seconds_r;

  acsc_state_t       state_r;
  acsc_state_t       state_nxt;
  acsc_strobe_t      strobe;

  logic              out_valid_r;
  logic [39:0]       out_data_r;
  logic              advance;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  acsc_next u_next (
    .cur     (state_r),
    .cmd     (in_cmd_r),
    .hours   (in_hours_r),
    .minutes (in_minutes_r),
    .seconds (in_seconds_r),
    .nxt     (state_nxt),
    .strobe  (strobe)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r     <= cmd_t'(in_tuser);
      in_hours_r   <= in_tdata[4:0];
      in_minutes_r <= in_tdata[10:5];
      in_seconds_r <= in_tdata[16:11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0,
                     (state_nxt.mode == MODE_RINGING),
                     strobe.set_clock,
                     strobe.save_alarm,
                     state_nxt.alarm_m,
                     state_nxt.alarm_h,
                     state_nxt.edit_s,
                     state_nxt.edit_m,
                     state_nxt.edit_h,
                     state_nxt.mode};
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the alarm clock set controller
// Sends events through the input stream and predicts each result with a
// cycle-free model of the mode, edit time, alarm and stored clock time. Every
// result from the output stream is compared field by field. Both sides idle
// in random bursts, the receiver holds off once for a long stretch, and the
// sender drains between phases.
// ----------------------------------------------------------------------------
module tb;
  import acsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_t       cmd;
    logic [4:0] hrs;
    logic [5:0] mins;
    logic [5:0] secs;
  } button_evt_t;

  typedef struct packed {
    mode_t      mode;
    logic [4:0] edit_h;
    logic [5:0] edit_m;
    logic [5:0] edit_s;
    logic [4:0] alarm_h;
    logic [5:0] alarm_m;
    logic       save_alarm;
    logic       set_clock;
    logic       ringing;
  } panel_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;   // command
  logic [23:0] in_tdata = '0;   // now_hours, now_minutes, now_seconds, zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // mode_now, edit_hours, edit_minutes, edit_seconds,
                                // alarm_hours_out, alarm_minutes_out, save_alarm,
                                // set_clock, ringing, zero pad

  button_evt_t  evt_pending[$];
  panel_state_t panel_expected[$];
  button_evt_t  evt_on_bus;
  panel_state_t panel_got;
  panel_state_t panel_want;

  // predicted controller state
  mode_t      ctl_mode;
  logic [4:0] ctl_edit_h, ctl_alarm_h, ctl_seen_h;
  logic [5:0] ctl_edit_m, ctl_edit_s, ctl_alarm_m, ctl_seen_m, ctl_seen_s;

  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned evts_queued = 0;
  logic        tail_calm = 1'b0;
  logic        hold_req = 1'b0;
  logic        out_hold = 1'b0;

  // alarm time as the stimulus side last loaded it, used to aim updates at it
  int unsigned aim_h = 0;
  int unsigned aim_m = 0;

  alarm_clock_set_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  function automatic panel_state_t advance_controller(button_evt_t e);
    panel_state_t r;
    logic         press;
    logic         save;
    logic         setc;
    press = (e.cmd == CMD_SHORT) || (e.cmd == CMD_LONG);
    save  = 1'b0;
    setc  = 1'b0;
    if (e.cmd == CMD_LOAD) begin
      ctl_alarm_h = e.hrs;
      ctl_alarm_m = e.mins;
    end else if (ctl_mode == MODE_NORMAL) begin
      if (press) begin
        ctl_edit_h = ctl_seen_h;
        ctl_edit_m = ctl_seen_m;
        ctl_mode   = (e.cmd == CMD_LONG) ? MODE_ALM_HR : MODE_CLK_HR;
      end
      if (press || e.cmd == CMD_UPDATE) begin
        ctl_seen_h = e.hrs;
        ctl_seen_m = e.mins;
        ctl_seen_s = e.secs;
      end
    end else if (ctl_mode == MODE_RINGING) begin
      if (press) begin
        ctl_seen_h = e.hrs;
        ctl_seen_m = e.mins;
        ctl_seen_s = e.secs;
        ctl_mode   = MODE_NORMAL;
      end
    end else if (press) begin
      if (ctl_mode <= MODE_ALM_SEC) begin
        ctl_alarm_h = ctl_edit_h;
        ctl_alarm_m = ctl_edit_m;
        save        = 1'b1;
      end else begin
        setc = 1'b1;
      end
      ctl_mode = MODE_NORMAL;
    end else begin
      case (e.cmd)
        CMD_UP: begin
          case (ctl_mode)
            MODE_ALM_HR, MODE_CLK_HR:   ctl_edit_h = 5'((int'(ctl_edit_h) + 1) % 24);
            MODE_ALM_MIN, MODE_CLK_MIN: ctl_edit_m = 6'((int'(ctl_edit_m) + 1) % 60);
            default:                    ctl_edit_s = 6'((int'(ctl_edit_s) + 1) % 60);
          endcase
        end
        CMD_DOWN: begin
          case (ctl_mode)
            MODE_ALM_HR, MODE_CLK_HR:   ctl_edit_h = (ctl_edit_h == 0) ? 5'd23 : ctl_edit_h - 5'd1;
            MODE_ALM_MIN, MODE_CLK_MIN: ctl_edit_m = (ctl_edit_m == 0) ? 6'd59 : ctl_edit_m - 6'd1;
            default:                    ctl_edit_s = (ctl_edit_s == 0) ? 6'd59 : ctl_edit_s - 6'd1;
          endcase
        end
        CMD_RIGHT: begin
          if (ctl_mode != MODE_ALM_SEC && ctl_mode != MODE_CLK_SEC) begin
            ctl_mode = mode_t'(ctl_mode + 3'd1);
          end
        end
        CMD_LEFT: begin
          // left stays inside its own setting group
          if (ctl_mode != MODE_ALM_HR && ctl_mode != MODE_CLK_HR) begin
            ctl_mode = mode_t'(ctl_mode - 3'd1);
          end
        end
        default: ;
      endcase
    end
    // alarm seconds are always zero
    if (ctl_seen_h == ctl_alarm_h && ctl_seen_m == ctl_alarm_m && ctl_seen_s == 0) begin
      ctl_mode = MODE_RINGING;
    end
    r.mode       = ctl_mode;
    r.edit_h     = ctl_edit_h;
    r.edit_m     = ctl_edit_m;
    r.edit_s     = ctl_edit_s;
    r.alarm_h    = ctl_alarm_h;
    r.alarm_m    = ctl_alarm_m;
    r.save_alarm = save;
    r.set_clock  = setc;
    r.ringing    = (ctl_mode == MODE_RINGING);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic push_evt(cmd_t c, int unsigned h, int unsigned m, int unsigned s);
    button_evt_t e;
    e.cmd  = c;
    e.hrs  = 5'(h);
    e.mins = 6'(m);
    e.secs = 6'(s);
    if (c == CMD_LOAD) begin
      aim_h = h;
      aim_m = m;
    end
    evt_pending.push_back(e);
    evts_queued++;
  endtask

  // seconds are zero now and then so that alarm matches can happen
  function automatic int unsigned pick_secs();
    return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 59);
  endfunction

  task automatic push_clock_evt(cmd_t c);
    push_evt(c, $urandom_range(0, 23), $urandom_range(0, 59), pick_secs());
  endtask

  task automatic add_random_session();
    int unsigned kind;
    int unsigned n;
    cmd_t        moves[6];
    moves = '{CMD_UP, CMD_DOWN, CMD_UP, CMD_DOWN, CMD_RIGHT, CMD_LEFT};
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      n = $urandom_range(1, 4);
      repeat (n - 1) push_clock_evt(CMD_UPDATE);
      if ($urandom_range(0, 4) == 0) begin
        push_evt(CMD_UPDATE, aim_h, aim_m, 0);
      end else begin
        push_clock_evt(CMD_UPDATE);
      end
    end else if (kind < 70) begin
      push_clock_evt($urandom_range(0, 1) ? CMD_LONG : CMD_SHORT);
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          push_clock_evt(CMD_UPDATE);
        end else begin
          push_evt(moves[$urandom_range(0, 5)], 0, 0, 0);
        end
      end
      push_clock_evt($urandom_range(0, 1) ? CMD_LONG : CMD_SHORT);
    end else if (kind < 80) begin
      push_evt(CMD_LOAD, $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    end else if (kind < 88) begin
      push_clock_evt($urandom_range(0, 1) ? CMD_LONG : CMD_SHORT);
    end else begin
      push_evt(cmd_t'($urandom_range(0, 7)), $urandom_range(0, 23),
               $urandom_range(0, 59), $urandom_range(0, 59));
    end
  endtask

  // wait until the sender has nothing left and every result is back
  task automatic drain();
    do begin
      @(posedge clk);
    end while (evt_pending.size() != 0 || in_tvalid || panel_expected.size() != 0);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        panel_expected.push_back(advance_controller(evt_on_bus));
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!tail_calm && $urandom_range(0, 15) == 0) begin
          send_gap  <= $urandom_range(0, 13);
          in_tvalid <= 1'b0;
        end else if (evt_pending.size() > 0) begin
          evt_on_bus = evt_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= evt_on_bus.cmd;
          in_tdata  <= {7'b0, evt_on_bus.secs, evt_on_bus.mins, evt_on_bus.hrs};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_hold) begin
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap   <= recv_gap - 1;
      out_tready <= 1'b0;
    end else if (!tail_calm && $urandom_range(0, 11) == 0) begin
      recv_gap   <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      panel_got.mode       = mode_t'(out_tdata[2:0]);
      panel_got.edit_h     = out_tdata[7:3];
      panel_got.edit_m     = out_tdata[13:8];
      panel_got.edit_s     = out_tdata[19:14];
      panel_got.alarm_h    = out_tdata[24:20];
      panel_got.alarm_m    = out_tdata[30:25];
      panel_got.save_alarm = out_tdata[31];
      panel_got.set_clock  = out_tdata[32];
      panel_got.ringing    = out_tdata[33];
      if (panel_expected.size() == 0) begin
        report_mismatch("result with no event waiting");
      end else begin
        panel_want = panel_expected.pop_front();
        check_field("mode_now", 8'(panel_got.mode), 8'(panel_want.mode));
        check_field("edit_hours", 8'(panel_got.edit_h), 8'(panel_want.edit_h));
        check_field("edit_minutes", 8'(panel_got.edit_m), 8'(panel_want.edit_m));
        check_field("edit_seconds", 8'(panel_got.edit_s), 8'(panel_want.edit_s));
        check_field("alarm_hours_out", 8'(panel_got.alarm_h), 8'(panel_want.alarm_h));
        check_field("alarm_minutes_out", 8'(panel_got.alarm_m), 8'(panel_want.alarm_m));
        check_field("save_alarm", 8'(panel_got.save_alarm), 8'(panel_want.save_alarm));
        check_field("set_clock", 8'(panel_got.set_clock), 8'(panel_want.set_clock));
        check_field("ringing", 8'(panel_got.ringing), 8'(panel_want.ringing));
      end
    end
  end

  // long receiver hold-off, so the input side backs up
  initial begin
    wait (hold_req);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (250) @(posedge clk);
    out_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    ctl_mode    = MODE_NORMAL;
    ctl_edit_h  = '0;
    ctl_edit_m  = '0;
    ctl_edit_s  = '0;
    ctl_alarm_h = '0;
    ctl_alarm_m = '0;
    ctl_seen_h  = '0;
    ctl_seen_m  = '0;
    ctl_seen_s  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: wraps, group edges, ignored moves, commits, ringing paths
    push_evt(CMD_LOAD, 7, 30, 0);
    push_evt(CMD_UPDATE, 23, 59, 59);
    push_evt(CMD_UP, 0, 0, 0);
    push_evt(CMD_LEFT, 0, 0, 0);
    push_evt(CMD_SHORT, 12, 34, 56);
    push_evt(CMD_UP, 0, 0, 0);
    push_evt(CMD_DOWN, 0, 0, 0);
    push_evt(CMD_LEFT, 0, 0, 0);
    push_evt(CMD_RIGHT, 0, 0, 0);
    push_evt(CMD_UP, 0, 0, 0);
    push_evt(CMD_RIGHT, 0, 0, 0);
    push_evt(CMD_DOWN, 0, 0, 0);
    push_evt(CMD_UP, 0, 0, 0);
    push_evt(CMD_RIGHT, 0, 0, 0);
    push_evt(CMD_UPDATE, 1, 2, 3);
    push_evt(CMD_SHORT, 9, 9, 9);
    push_evt(CMD_LONG, 7, 29, 0);
    push_evt(CMD_RIGHT, 0, 0, 0);
    push_evt(CMD_RIGHT, 0, 0, 0);
    push_evt(CMD_LEFT, 0, 0, 0);
    push_evt(CMD_DOWN, 0, 0, 0);
    push_evt(CMD_LONG, 3, 3, 3);
    push_evt(CMD_LOAD, 7, 29, 0);
    push_evt(CMD_DOWN, 0, 0, 0);
    push_evt(CMD_SHORT, 7, 29, 0);
    push_evt(CMD_LONG, 0, 0, 0);
    push_evt(CMD_LONG, 0, 0, 0);
    push_evt(CMD_LOAD, 0, 0, 0);
    push_evt(CMD_SHORT, 5, 5, 5);
    drain();

    while (evts_queued < 530) add_random_session();
    hold_req = 1'b1;
    drain();

    while (evts_queued < 1030) add_random_session();
    while (evt_pending.size() > 150) @(posedge clk);
    tail_calm <= 1'b1;
    drain();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && panel_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
